FILE: rtl/ptrt_pkg.sv
// ----------------------------------------------------------------------------
// ptrt_pkg
// Shared widths, defaults and item codes for the ping round-trip tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptrt_pkg;

	localparam int TAG_W           = 16;
	localparam int TIME_W          = 48;
	localparam int AVG_W           = 31;
	localparam int PING_SLOTS_DEF  = 10;

	localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

	localparam logic KIND_SEND  = 1'b0;
	localparam logic KIND_REPLY = 1'b1;

endpackage

FILE: rtl/ping_round_trip_tracker_unit.sv
// ----------------------------------------------------------------------------
// ping_round_trip_tracker_unit
// Ring of ping slots with tag allocation, reply stamping and a running
// mean half round trip, worked out by a slot walk and a serial divider.
// ----------------------------------------------------------------------------
//  channel | handshake           | fields
//  in      | in_valid / in_ready | kind, now_ms, reply_tag
//  out     | out_valid/out_ready | sent_tag, average_ms
//
//  A send first writes its new slot, a reply goes straight to the walk; then
//  a slot walk at one read a cycle, then one quotient bit a cycle. No
//  completed slot, a sum not above zero or a saturated mean skip the divide.
//  in_ready is high in idle only, from the cycle after the result is loaded;
//  a held result stalls the next word at its end. Reset clears all slots at
//  once through per-slot valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ping_round_trip_tracker_unit #(
	parameter int PING_SLOTS = ptrt_pkg::PING_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic [ptrt_pkg::TIME_W-1:0]  now_ms,
	input  logic [ptrt_pkg::TAG_W-1:0]   reply_tag,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ptrt_pkg::TAG_W-1:0]   sent_tag,
	output logic [ptrt_pkg::AVG_W-1:0]   average_ms
);

	localparam int AW     = $clog2(PING_SLOTS);
	localparam int CW     = $clog2(PING_SLOTS + 1);
	localparam int SW     = ptrt_pkg::TIME_W + CW + 1;
	localparam int HW     = SW - 1 - ptrt_pkg::AVG_W;
	localparam int STEP_W = $clog2(ptrt_pkg::AVG_W);
	localparam int TW     = ptrt_pkg::TIME_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,
		S_SCAN,
		S_DINIT,
		S_DIV,
		S_FIN
	} state_t;

	state_t                         state_q;
	logic                           kind_q;
	logic [TW-1:0]                  now_q;
	logic [ptrt_pkg::TAG_W-1:0]     reply_q;
	logic [ptrt_pkg::TAG_W-1:0]     tag_q;
	logic [AW-1:0]                  newest_q;
	logic [CW-1:0]                  idx_q;
	logic                           pv_q;
	logic [AW-1:0]                  pidx_q;
	logic                           matched_q;
	logic signed [SW-1:0]           sum_q;
	logic [CW-1:0]                  cnt_q;
	logic [CW:0]                    rem_q;
	logic [ptrt_pkg::AVG_W-1:0]     quo_q;
	logic [STEP_W-1:0]              step_q;
	logic [ptrt_pkg::AVG_W-1:0]     avg_q;
	logic                           out_valid_q;
	logic [ptrt_pkg::TAG_W-1:0]     sent_tag_q;
	logic [ptrt_pkg::AVG_W-1:0]     average_q;

	logic                           wr_en;
	logic [AW-1:0]                  wr_addr;
	logic [ptrt_pkg::TAG_W-1:0]     wr_tag;
	logic [TW-1:0]                  wr_sent;
	logic [TW-1:0]                  wr_recv;
	logic [AW-1:0]                  rd_addr;
	logic [ptrt_pkg::TAG_W-1:0]     rd_tag;
	logic [TW-1:0]                  rd_sent;
	logic [TW-1:0]                  rd_recv;

	logic [AW-1:0]                  head_nxt;
	logic [ptrt_pkg::TAG_W-1:0]     tag_nxt;
	logic                           hit;
	logic [TW-1:0]                  recv_eff;
	logic                           slot_done;
	logic signed [TW:0]             delta;
	logic signed [SW-1:0]           sum_add;
	logic [CW:0]                    divisor;
	logic [HW-1:0]                  sum_hi;
	logic                           sum_pos;
	logic [CW+1:0]                  rem2;
	logic [CW+1:0]                  rem_sub;
	logic                           ge;
	logic                           issue;

	ptrt_slot_ram #(
		.PING_SLOTS (PING_SLOTS),
		.AW         (AW)
	) u_slots (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_tag  (wr_tag),
		.wr_sent (wr_sent),
		.wr_recv (wr_recv),
		.rd_addr (rd_addr),
		.rd_tag  (rd_tag),
		.rd_sent (rd_sent),
		.rd_recv (rd_recv)
	);

	assign issue   = (idx_q < CW'(PING_SLOTS));
	// idle: newest slot read so its tag is ready for a send
	assign rd_addr = (state_q == S_IDLE) ? newest_q :
		(issue ? idx_q[AW-1:0] : '0);

	assign head_nxt = (newest_q == AW'(PING_SLOTS - 1)) ? '0 : newest_q + 1'b1;
	assign tag_nxt  = rd_tag + 1'b1;

	// only the first matching slot in index order takes the reply
	assign hit = (state_q == S_SCAN) && pv_q && (kind_q == ptrt_pkg::KIND_REPLY)
		&& !matched_q && (rd_tag == reply_q);
	assign recv_eff  = hit ? now_q : rd_recv;
	assign slot_done = (rd_sent != '0) && (recv_eff != '0);
	assign delta     = $signed({1'b0, recv_eff}) - $signed({1'b0, rd_sent});
	assign sum_add   = sum_q + $signed({{(SW-TW-1){delta[TW]}}, delta});

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pidx_q;
		wr_tag  = rd_tag;
		wr_sent = rd_sent;
		wr_recv = now_q;
		if (state_q == S_WRITE) begin
			wr_en   = 1'b1;
			wr_addr = head_nxt;
			wr_tag  = tag_nxt;
			wr_sent = now_q;
			wr_recv = '0;
		end else if (hit) begin
			wr_en = 1'b1;
		end
	end

	assign divisor = {cnt_q, 1'b0};
	assign sum_hi  = sum_q[SW-2:ptrt_pkg::AVG_W];
	assign sum_pos = !sum_q[SW-1] && (sum_q != '0);
	assign rem2    = {rem_q, quo_q[ptrt_pkg::AVG_W-1]};
	assign ge      = (rem2 >= {1'b0, divisor});
	assign rem_sub = rem2 - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			newest_q    <= '0;
			idx_q       <= '0;
			pv_q        <= 1'b0;
			pidx_q      <= '0;
			matched_q   <= 1'b0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			kind_q      <= ptrt_pkg::KIND_SEND;
			cnt_q       <= '0;
			now_q       <= '0;
			reply_q     <= '0;
			tag_q       <= '0;
			sum_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			avg_q       <= '0;
			sent_tag_q  <= '0;
			average_q   <= '0;
		end else begin
			// a result loaded in S_FIN takes over the output register itself
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q    <= kind;
						now_q     <= now_ms;
						reply_q   <= reply_tag;
						tag_q     <= '0;
						idx_q     <= '0;
						pv_q      <= 1'b0;
						matched_q <= 1'b0;
						sum_q     <= '0;
						cnt_q     <= '0;
						state_q   <= (kind == ptrt_pkg::KIND_SEND) ? S_WRITE : S_SCAN;
					end
				end
				S_WRITE: begin
					newest_q <= head_nxt;
					tag_q    <= tag_nxt;
					state_q  <= S_SCAN;
				end
				S_SCAN: begin
					if (issue) begin
						pv_q   <= 1'b1;
						pidx_q <= idx_q[AW-1:0];
						idx_q  <= idx_q + 1'b1;
					end else begin
						pv_q <= 1'b0;
					end
					if (pv_q) begin
						if (hit) begin
							matched_q <= 1'b1;
						end
						if (slot_done) begin
							sum_q <= sum_add;
							cnt_q <= cnt_q + 1'b1;
						end
						if (pidx_q == AW'(PING_SLOTS - 1)) begin
							state_q <= S_DINIT;
						end
					end
				end
				S_DINIT: begin
					if (cnt_q == '0 || !sum_pos) begin
						avg_q   <= '0;
						state_q <= S_FIN;
					end else if (sum_hi >= HW'(divisor)) begin
						avg_q   <= ptrt_pkg::AVG_MAX;
						state_q <= S_FIN;
					end else begin
						// top bits already below the divisor: quotient fits AVG_W
						rem_q   <= sum_hi[CW:0];
						quo_q   <= sum_q[ptrt_pkg::AVG_W-1:0];
						step_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q  <= ge ? rem_sub[CW:0] : rem2[CW:0];
					quo_q  <= {quo_q[ptrt_pkg::AVG_W-2:0], ge};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(ptrt_pkg::AVG_W - 1)) begin
						avg_q   <= {quo_q[ptrt_pkg::AVG_W-2:0], ge};
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						sent_tag_q  <= tag_q;
						average_q   <= avg_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign sent_tag   = sent_tag_q;
	assign average_ms = average_q;

	a_newest_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		newest_q <= AW'(PING_SLOTS - 1))
		else $error("newest slot index outside the ring");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && pv_q) |-> (pidx_q <= AW'(PING_SLOTS - 1)))
		else $error("slot walk past the last slot");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < divisor))
		else $error("divider remainder not below divisor");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again before the walk");

endmodule

FILE: rtl/ptrt_slot_ram.sv
// ----------------------------------------------------------------------------
// ptrt_slot_ram
// Slot store: tag, send and receive time per slot, one write and one
// registered read a cycle. Per-entry valid bits make unwritten slots read zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptrt_slot_ram #(
	parameter int PING_SLOTS = ptrt_pkg::PING_SLOTS_DEF,
	parameter int AW         = $clog2(PING_SLOTS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [ptrt_pkg::TAG_W-1:0]  wr_tag,
	input  logic [ptrt_pkg::TIME_W-1:0] wr_sent,
	input  logic [ptrt_pkg::TIME_W-1:0] wr_recv,
	input  logic [AW-1:0]               rd_addr,
	output logic [ptrt_pkg::TAG_W-1:0]  rd_tag,
	output logic [ptrt_pkg::TIME_W-1:0] rd_sent,
	output logic [ptrt_pkg::TIME_W-1:0] rd_recv
);

	logic [ptrt_pkg::TAG_W-1:0]  mem_tag  [PING_SLOTS];
	logic [ptrt_pkg::TIME_W-1:0] mem_sent [PING_SLOTS];
	logic [ptrt_pkg::TIME_W-1:0] mem_recv [PING_SLOTS];
	logic [PING_SLOTS-1:0]       vld_q;

	logic [ptrt_pkg::TAG_W-1:0]  rd_tag_q;
	logic [ptrt_pkg::TIME_W-1:0] rd_sent_q;
	logic [ptrt_pkg::TIME_W-1:0] rd_recv_q;
	logic                        rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_tag[wr_addr]  <= wr_tag;
			mem_sent[wr_addr] <= wr_sent;
			mem_recv[wr_addr] <= wr_recv;
		end
		rd_tag_q  <= mem_tag[rd_addr];
		rd_sent_q <= mem_sent[rd_addr];
		rd_recv_q <= mem_recv[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	// never-written slot reads as zero
	assign rd_tag  = rd_vld_q ? rd_tag_q  : '0;
	assign rd_sent = rd_vld_q ? rd_sent_q : '0;
	assign rd_recv = rd_vld_q ? rd_recv_q : '0;

endmodule
